### rtl/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared types and constants of the first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

   // Bitmap word geometry
   localparam int WORD_BITS  = 32;
   localparam int WORD_SHIFT = 5;
   localparam int POS_W      = 5;

   // Field widths
   localparam int OP_W     = 2;
   localparam int WIDX_W   = 8;
   localparam int GROUP_W  = 16;
   localparam int LIMIT_W  = 14;
   localparam int NUMBER_W = 32;
   localparam int PROD_W   = GROUP_W + LIMIT_W;

   // Request operations
   typedef enum logic [OP_W-1:0] {
      OP_LOAD  = 2'd0,
      OP_READ  = 2'd1,
      OP_ALLOC = 2'd2,
      OP_CLEAR = 2'd3
   } bffa_op_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_RESP
   } bffa_state_type;

   // Outcome of the search in one bitmap word
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
   } bffa_pick_type;

endpackage

### rtl/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bffa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                            clock,
   input  logic                                            wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    wr_addr,
   input  logic [WIDTH-1:0]                                wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    rd_addr,
   output logic [WIDTH-1:0]                                rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bffa_pick.sv
// ----------------------------------------------------------------------------
// bffa_pick
// Finds the lowest clear bit of one bitmap word, ignoring bits at or above
// the limit when the word is the last one in range.
// ----------------------------------------------------------------------------
module bffa_pick
   import bffa_pkg::*;
(
   input  logic [WORD_BITS-1:0] word,
   input  logic                 is_last,
   input  logic [POS_W-1:0]     tail,
   output bffa_pick_type        pick
);

   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] free_bits;

   // Keep bits up to the tail position in the last word, all bits otherwise
   always_comb begin
      valid_mask = is_last ? ({WORD_BITS{1'b1}} >> (~tail)) : {WORD_BITS{1'b1}};
      free_bits  = ~word & valid_mask;
   end

   // Priority encode the lowest free bit
   always_comb begin
      pick.found = |free_bits;
      pick.pos   = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            pick.pos = POS_W'(i);
         end
      end
   end

endmodule

### rtl/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer of the allocator: load, read back, first-fit scan with
// read-modify-write of the bitmap RAM, dirty flag and result register.
// ----------------------------------------------------------------------------
module bffa_ctrl
   import bffa_pkg::*;
#(
   parameter int MAP_BITS = 8192
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OP_W-1:0]         req_op,
   input  logic [WIDX_W-1:0]       req_word_index,
   input  logic [WORD_BITS-1:0]    req_word_data,
   input  logic [GROUP_W-1:0]      req_group,
   // configuration
   input  logic [LIMIT_W-1:0]      total_bits,
   // result channel
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [NUMBER_W-1:0]     rsp_number,
   output logic                    rsp_found,
   output logic [WORD_BITS-1:0]    rsp_read_data,
   output logic                    rsp_dirty,
   // bitmap RAM
   output logic                    ram_wr_en,
   output logic [((((MAP_BITS + 31) / 32) > 1) ? $clog2((MAP_BITS + 31) / 32) : 1)-1:0]
                                   ram_wr_addr,
   output logic [WORD_BITS-1:0]    ram_wr_data,
   output logic [((((MAP_BITS + 31) / 32) > 1) ? $clog2((MAP_BITS + 31) / 32) : 1)-1:0]
                                   ram_rd_addr,
   input  logic [WORD_BITS-1:0]    ram_rd_data
);

   localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   bffa_state_type        state_ff, state_in;
   logic [AW-1:0]         word_ff, word_in;
   logic [AW-1:0]         last_ff, last_in;
   logic [POS_W-1:0]      tail_ff, tail_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic                  in_range_ff, in_range_in;
   logic                  dirty_ff, dirty_in;
   logic [NUMBER_W-1:0]   res_number_ff, res_number_in;
   logic                  res_found_ff, res_found_in;
   logic [WORD_BITS-1:0]  res_read_data_ff, res_read_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_W-1:0]   rsp_number_ff, rsp_number_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [WORD_BITS-1:0]  rsp_read_data_ff, rsp_read_data_in;
   logic                  rsp_dirty_ff, rsp_dirty_in;

   logic [31:0]           limit;
   logic [31:0]           limit_m1;
   logic                  idx_in_range;
   bffa_op_type           op;
   bffa_pick_type         pick;

   // Effective scan limit: the configured count, capped at the map size
   always_comb begin
      limit        = (32'(total_bits) < 32'(MAP_BITS)) ? 32'(total_bits) : 32'(MAP_BITS);
      limit_m1     = limit - 32'd1;
      idx_in_range = (32'(req_word_index) < 32'(MAP_WORDS));
      op           = bffa_op_type'(req_op);
   end

   // Search the word that the RAM returns this cycle
   bffa_pick u_pick (
      .word    (ram_rd_data),
      .is_last (word_ff == last_ff),
      .tail    (tail_ff),
      .pick    (pick)
   );

   // Next state and datapath control
   always_comb begin
      state_in         = state_ff;
      word_in          = word_ff;
      last_in          = last_ff;
      tail_in          = tail_ff;
      prod_in          = prod_ff;
      in_range_in      = in_range_ff;
      dirty_in         = dirty_ff;
      res_number_in    = res_number_ff;
      res_found_in     = res_found_ff;
      res_read_data_in = res_read_data_ff;
      rsp_valid_in     = rsp_valid_ff & ~rsp_ready;
      rsp_number_in    = rsp_number_ff;
      rsp_found_in     = rsp_found_ff;
      rsp_read_data_in = rsp_read_data_ff;
      rsp_dirty_in     = rsp_dirty_ff;
      req_ready        = 1'b0;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = AW'(req_word_index);
      ram_wr_data      = req_word_data;
      ram_rd_addr      = AW'(req_word_index);

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_number_in    = '0;
               res_found_in     = 1'b0;
               res_read_data_in = '0;
               in_range_in      = idx_in_range;
               case (op)
                  OP_LOAD: begin
                     ram_wr_en = idx_in_range;
                     state_in  = ST_RESP;
                  end
                  OP_READ: begin
                     state_in = ST_READ;
                  end
                  OP_ALLOC: begin
                     prod_in     = PROD_W'(req_group) * PROD_W'(total_bits);
                     ram_rd_addr = '0;
                     word_in     = '0;
                     last_in     = AW'(limit_m1 >> WORD_SHIFT);
                     tail_in     = limit_m1[POS_W-1:0];
                     state_in    = (limit == 32'd0) ? ST_RESP : ST_SCAN;
                  end
                  OP_CLEAR: begin
                     dirty_in = 1'b0;
                     state_in = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_READ: begin
            res_read_data_in = in_range_ff ? ram_rd_data : '0;
            state_in         = ST_RESP;
         end

         ST_SCAN: begin
            // fetch the next word while this one is checked
            ram_rd_addr = word_ff + 1'b1;
            ram_wr_addr = word_ff;
            ram_wr_data = ram_rd_data | (WORD_BITS'(1) << pick.pos);
            if (pick.found) begin
               ram_wr_en     = 1'b1;
               res_number_in = NUMBER_W'(prod_ff) + NUMBER_W'({word_ff, pick.pos})
                               + NUMBER_W'(1);
               res_found_in  = 1'b1;
               dirty_in      = 1'b1;
               state_in      = ST_RESP;
            end else if (word_ff == last_ff) begin
               state_in = ST_RESP;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end

         ST_RESP: begin
            // move the result into the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_number_in    = res_number_ff;
               rsp_found_in     = res_found_ff;
               rsp_read_data_in = res_read_data_ff;
               rsp_dirty_in     = dirty_ff;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      word_ff          <= word_in;
      last_ff          <= last_in;
      tail_ff          <= tail_in;
      prod_ff          <= prod_in;
      in_range_ff      <= in_range_in;
      res_number_ff    <= res_number_in;
      res_found_ff     <= res_found_in;
      res_read_data_ff <= res_read_data_in;
      rsp_number_ff    <= rsp_number_in;
      rsp_found_ff     <= rsp_found_in;
      rsp_read_data_ff <= rsp_read_data_in;
      rsp_dirty_ff     <= rsp_dirty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_number    = rsp_number_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_read_data = rsp_read_data_ff;
   assign rsp_dirty     = rsp_dirty_ff;

endmodule

### rtl/bitmap_first_free_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_top
// First-fit bitmap allocator with a RAM-held bitmap and a dirty flag.
// ----------------------------------------------------------------------------
// The bitmap (one bit per object, 0 = free) lives in a single RAM of
// MAP_BITS/32 words with a registered read. Items are handled one at a
// time. From acceptance to a valid result, load and clear-dirty pass
// through ST_RESP, read through ST_READ and ST_RESP, and allocate through
// one ST_SCAN step per bitmap word scanned and then ST_RESP; the scan reads
// one word per cycle from the RAM's single read port and writes the found
// word back on the cycle it is checked. The next item is taken as soon as
// the result is in the output register, even while it waits for rsp_ready.
// Words never loaded read back as unknown, so software must load every word
// below the limit before allocating. csr_total_bits may only be written
// while the block is idle.
// ----------------------------------------------------------------------------
module bitmap_first_free_allocator_top
   import bffa_pkg::*;
#(
   parameter int MAP_BITS = 8192
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_op,
   input  logic [WIDX_W-1:0]     req_word_index,
   input  logic [WORD_BITS-1:0]  req_word_data,
   input  logic [GROUP_W-1:0]    req_group,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [NUMBER_W-1:0]   rsp_number,
   output logic                  rsp_found,
   output logic [WORD_BITS-1:0]  rsp_read_data,
   output logic                  rsp_dirty,
   // configuration
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [LIMIT_W-1:0]    csr_total_bits
);

   localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

   logic [LIMIT_W-1:0]   total_bits_ff;
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // Limit register, written at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_bits_ff <= LIMIT_W'(8192);
      end else if (csr_valid) begin
         total_bits_ff <= csr_total_bits;
      end
   end

   bffa_ctrl #(
      .MAP_BITS (MAP_BITS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .req_group      (req_group),
      .total_bits     (total_bits_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_number     (rsp_number),
      .rsp_found      (rsp_found),
      .rsp_read_data  (rsp_read_data),
      .rsp_dirty      (rsp_dirty),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .ram_rd_addr    (ram_rd_addr),
      .ram_rd_data    (ram_rd_data)
   );

   bffa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAP_WORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule
